[sv/pbde_pkg.sv]
// ---------------------------------------------------------------------------
// pbde_pkg
// Shared types and constants of the run-length and delta elevation decoder.
// ---------------------------------------------------------------------------
package pbde_pkg;

  localparam int GRID_W     = 13;
  localparam int ELEV_W     = 16;
  localparam int BYTE_W     = 8;
  localparam int OUT_LANES  = 4;
  localparam int LANE_IDX_W = 2;
  localparam int LANE_CNT_W = 3;
  localparam int FEED_W     = 8;

  localparam logic [GRID_W-1:0] GRID_RESET  = 13'd258;
  localparam logic [BYTE_W-1:0] ESCAPE_BYTE = 8'h80;
  localparam logic signed [ELEV_W-1:0] ELEV_MIN = 16'sh8000;
  localparam logic signed [ELEV_W-1:0] ELEV_MAX = 16'sh7FFF;

  typedef enum logic [2:0] {
    PH_CNT_HI,
    PH_CNT_LO,
    PH_CODE,
    PH_REP_VAL,
    PH_LITERAL
  } byte_phase_t;

  typedef enum logic [1:0] {
    DP_HIGH,
    DP_LOW,
    DP_RUN
  } delta_phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FEED,
    ST_FLUSH
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic feed;
    logic flush;
  } pbde_cmd_t;

  typedef struct packed {
    logic acc_feeds;
    logic acc_row_done;
    logic feed_last;
    logic feed_push;
    logic end_flush;
    logic out_free;
  } pbde_status_t;

endpackage

[sv/packbits_delta_elevation_decoder_core.sv]
// ---------------------------------------------------------------------------
// packbits_delta_elevation_decoder_core
// Decodes a row-counted PackBits stream of delta-coded 16-bit elevations
// into groups of four, with row/grid markers and running min/max.
//
//   channel   signals                          direction
//   in        in_valid, in_stall, data_byte    byte stream in
//   out       out_valid, out_stall, lanes...   elevation groups out
//   cfg       cfg_valid, cfg_ready, grid_size  grid_size register write
//
// Count and code bytes are only taken in, plus a flush when they close a row.
// A literal byte is taken in and fed as one delta step, plus a flush when it
// yields an elevation or closes the row; a repeat value byte is fed as run length
// (1..129) delta steps plus the same flush, one per cycle unless the sequencer is held.
// A full group or a flush waiting on out_stall holds the sequencer; in_stall is
// high whenever the sequencer is not idle. Synchronous reset, no clearing pass.
// ---------------------------------------------------------------------------
module packbits_delta_elevation_decoder_core
  import pbde_pkg::*;
#(
  parameter int MAX_GRID = 4096
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [BYTE_W-1:0]        data_byte,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [ELEV_W-1:0] elev_lane0,
  output logic signed [ELEV_W-1:0] elev_lane1,
  output logic signed [ELEV_W-1:0] elev_lane2,
  output logic signed [ELEV_W-1:0] elev_lane3,
  output logic [LANE_CNT_W-1:0]    lane_count,
  output logic                     row_end,
  output logic                     grid_end,
  output logic                     short_row,
  output logic signed [ELEV_W-1:0] running_min,
  output logic signed [ELEV_W-1:0] running_max,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [GRID_W-1:0]        grid_size
);

  localparam int GW = ($clog2(MAX_GRID + 1) > GRID_W) ? $clog2(MAX_GRID + 1) : GRID_W;

  logic [GRID_W-1:0]        grid_cfg;
  logic [GW-1:0]            grid_ext;
  logic [GW-1:0]            grid_eff;
  pbde_cmd_t                cmd;
  pbde_status_t             status;
  logic signed [ELEV_W-1:0] out_lane [OUT_LANES];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cfg <= GRID_RESET;
    end else if (cfg_valid && cfg_ready) begin
      grid_cfg <= grid_size;
    end
  end

  assign grid_ext = GW'(grid_cfg);

  always_comb begin
    if (grid_ext < GW'(2)) begin
      grid_eff = GW'(2);
    end else if (grid_ext > GW'(MAX_GRID)) begin
      grid_eff = GW'(MAX_GRID);
    end else begin
      grid_eff = grid_ext;
    end
  end

  pbde_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  pbde_datapath #(
    .GW       (GW)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .grid_eff    (grid_eff),
    .data_byte   (data_byte),
    .cmd         (cmd),
    .status      (status),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_lane    (out_lane),
    .lane_count  (lane_count),
    .row_end     (row_end),
    .grid_end    (grid_end),
    .short_row   (short_row),
    .running_min (running_min),
    .running_max (running_max)
  );

  assign elev_lane0 = out_lane[0];
  assign elev_lane1 = out_lane[1];
  assign elev_lane2 = out_lane[2];
  assign elev_lane3 = out_lane[3];

endmodule

[sv/pbde_ctrl.sv]
// ---------------------------------------------------------------------------
// pbde_ctrl
// Sequencer: byte intake, one delta step per cycle unless a full group is held, final group flush.
// ---------------------------------------------------------------------------
module pbde_ctrl
  import pbde_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  pbde_status_t status,
  output pbde_cmd_t    cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (status.acc_feeds) begin
            state_next = ST_FEED;
          end else if (status.acc_row_done) begin
            state_next = ST_FLUSH;
          end
        end
      end
      ST_FEED: begin
        if ((!status.feed_push || status.out_free) && status.feed_last) begin
          state_next = status.end_flush ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = 1'b1;
    cmd.accept = 1'b0;
    cmd.feed   = 1'b0;
    cmd.flush  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      ST_FEED:  cmd.feed  = !status.feed_push || status.out_free;
      ST_FLUSH: cmd.flush = status.out_free;
      default: ;
    endcase
  end

endmodule

[sv/pbde_datapath.sv]
// ---------------------------------------------------------------------------
// pbde_datapath
// Row/code parser, delta accumulator, lane packer, min/max and output register.
// ---------------------------------------------------------------------------
module pbde_datapath
  import pbde_pkg::*;
#(
  parameter int GW = 13
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [GW-1:0]            grid_eff,
  input  logic [BYTE_W-1:0]        data_byte,
  input  pbde_cmd_t                cmd,
  output pbde_status_t             status,
  input  logic                     out_stall,
  output logic                     out_valid,
  output logic signed [ELEV_W-1:0] out_lane [OUT_LANES],
  output logic [LANE_CNT_W-1:0]    lane_count,
  output logic                     row_end,
  output logic                     grid_end,
  output logic                     short_row,
  output logic signed [ELEV_W-1:0] running_min,
  output logic signed [ELEV_W-1:0] running_max
);

  byte_phase_t              byte_phase, byte_phase_next;
  logic [15:0]              payload_left, payload_left_next;
  logic [BYTE_W-1:0]        count_high_hold, count_high_hold_next;
  logic [BYTE_W-1:0]        literal_left, literal_left_next;
  logic [BYTE_W-1:0]        repeat_count, repeat_count_next;
  delta_phase_t             delta_phase, delta_phase_next;
  logic [BYTE_W-1:0]        base_high_hold, base_high_hold_next;
  logic [ELEV_W-1:0]        cur_elev, cur_elev_next;
  logic [GW-1:0]            row_elev_count, row_elev_count_next;
  logic [GRID_W-1:0]        row_index, row_index_next;
  logic signed [ELEV_W-1:0] min_seen, min_seen_next;
  logic signed [ELEV_W-1:0] max_seen, max_seen_next;
  logic [FEED_W-1:0]        feed_left, feed_left_next;
  logic                     row_done, row_done_next;
  logic [LANE_CNT_W-1:0]    buf_cnt, buf_cnt_next;
  logic                     out_valid_next;
  logic [BYTE_W-1:0]        byte_q;
  logic [ELEV_W-1:0]        lanes [OUT_LANES];

  // delta step on the held byte
  logic                     elev_now;
  delta_phase_t             fd_phase;
  logic [BYTE_W-1:0]        fd_base;
  logic [ELEV_W-1:0]        fd_elev;
  logic signed [ELEV_W-1:0] fd_selev;
  logic                     buf_full;
  logic                     push;

  // byte intake
  logic [15:0]              pl_dec;
  logic [BYTE_W-1:0]        lit_dec;
  logic                     acc_row_done;
  logic                     acc_feeds;

  // row close
  logic [GRID_W-1:0]        ri_inc;
  logic                     close_grid;
  logic                     close_short;

  assign buf_full = (buf_cnt == LANE_CNT_W'(OUT_LANES));
  assign fd_selev = $signed(fd_elev);

  always_comb begin
    elev_now = 1'b0;
    fd_phase = delta_phase;
    fd_base  = base_high_hold;
    fd_elev  = cur_elev;
    if (row_elev_count < grid_eff) begin
      case (delta_phase)
        DP_HIGH: begin
          fd_base  = byte_q;
          fd_phase = DP_LOW;
        end
        DP_LOW: begin
          fd_elev  = {base_high_hold, byte_q};
          fd_phase = DP_RUN;
          elev_now = 1'b1;
        end
        default: begin
          if (byte_q == ESCAPE_BYTE) begin
            fd_phase = DP_HIGH;
          end else begin
            fd_elev  = cur_elev + {{(ELEV_W-BYTE_W){byte_q[BYTE_W-1]}}, byte_q};
            fd_phase = DP_RUN;
            elev_now = 1'b1;
          end
        end
      endcase
    end
  end

  assign pl_dec  = payload_left - 16'd1;
  assign lit_dec = (literal_left != '0) ? literal_left - 8'd1 : literal_left;

  always_comb begin
    acc_row_done = 1'b0;
    acc_feeds    = 1'b0;
    case (byte_phase)
      PH_CNT_LO:  acc_row_done = ({count_high_hold, data_byte} == 16'd0);
      PH_CODE:    acc_row_done = (pl_dec == 16'd0);
      PH_REP_VAL,
      PH_LITERAL: begin
        acc_row_done = (pl_dec == 16'd0);
        acc_feeds    = 1'b1;
      end
      default: ;
    endcase
  end

  assign ri_inc      = row_index + GRID_W'(1);
  assign close_grid  = (GW'(ri_inc) >= grid_eff);
  assign close_short = (row_elev_count < grid_eff);

  assign push = (cmd.feed && elev_now && buf_full) || cmd.flush;

  assign status.acc_feeds    = acc_feeds;
  assign status.acc_row_done = acc_row_done;
  assign status.feed_last    = (feed_left == FEED_W'(1));
  assign status.feed_push    = elev_now && buf_full;
  assign status.end_flush    = row_done || (buf_cnt != '0) || elev_now;
  assign status.out_free     = !out_valid || !out_stall;

  always_comb begin
    byte_phase_next      = byte_phase;
    payload_left_next    = payload_left;
    count_high_hold_next = count_high_hold;
    literal_left_next    = literal_left;
    repeat_count_next    = repeat_count;
    delta_phase_next     = delta_phase;
    base_high_hold_next  = base_high_hold;
    cur_elev_next        = cur_elev;
    row_elev_count_next  = row_elev_count;
    row_index_next       = row_index;
    min_seen_next        = min_seen;
    max_seen_next        = max_seen;
    feed_left_next       = feed_left;
    row_done_next        = row_done;
    buf_cnt_next         = buf_cnt;
    out_valid_next       = out_valid && out_stall;

    if (cmd.accept) begin
      row_done_next = acc_row_done;
      case (byte_phase)
        PH_CNT_HI: begin
          count_high_hold_next = data_byte;
          byte_phase_next      = PH_CNT_LO;
        end
        PH_CNT_LO: begin
          payload_left_next   = {count_high_hold, data_byte};
          row_elev_count_next = '0;
          delta_phase_next    = DP_HIGH;
          literal_left_next   = '0;
          repeat_count_next   = '0;
          byte_phase_next     = PH_CODE;
        end
        PH_CODE: begin
          payload_left_next = pl_dec;
          if (data_byte == '0 || data_byte[BYTE_W-1]) begin
            repeat_count_next = 8'd0 - data_byte;
            byte_phase_next   = PH_REP_VAL;
          end else begin
            literal_left_next = data_byte + 8'd1;
            byte_phase_next   = PH_LITERAL;
          end
        end
        PH_REP_VAL: begin
          payload_left_next = pl_dec;
          feed_left_next    = repeat_count + 8'd1;
          byte_phase_next   = PH_CODE;
        end
        PH_LITERAL: begin
          payload_left_next = pl_dec;
          feed_left_next    = FEED_W'(1);
          literal_left_next = lit_dec;
          if (lit_dec == '0) begin
            byte_phase_next = PH_CODE;
          end
        end
        default: byte_phase_next = PH_CNT_HI;
      endcase
      if (acc_row_done) begin
        byte_phase_next   = PH_CNT_HI;
        literal_left_next = '0;
        repeat_count_next = '0;
      end
    end

    if (cmd.feed) begin
      feed_left_next      = feed_left - FEED_W'(1);
      delta_phase_next    = fd_phase;
      base_high_hold_next = fd_base;
      cur_elev_next       = fd_elev;
      if (elev_now) begin
        row_elev_count_next = row_elev_count + GW'(1);
        buf_cnt_next        = buf_full ? LANE_CNT_W'(1) : buf_cnt + LANE_CNT_W'(1);
        if (fd_selev < min_seen) begin
          min_seen_next = fd_selev;
        end
        if (fd_selev > max_seen) begin
          max_seen_next = fd_selev;
        end
      end
    end

    if (cmd.flush) begin
      buf_cnt_next  = '0;
      row_done_next = 1'b0;
      if (row_done) begin
        row_index_next = close_grid ? '0 : ri_inc;
        if (close_grid) begin
          min_seen_next = ELEV_MAX;
          max_seen_next = ELEV_MIN;
        end
      end
    end

    if (push) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase      <= PH_CNT_HI;
      payload_left    <= '0;
      count_high_hold <= '0;
      literal_left    <= '0;
      repeat_count    <= '0;
      delta_phase     <= DP_HIGH;
      base_high_hold  <= '0;
      cur_elev        <= '0;
      row_elev_count  <= '0;
      row_index       <= '0;
      min_seen        <= ELEV_MAX;
      max_seen        <= ELEV_MIN;
      feed_left       <= '0;
      row_done        <= 1'b0;
      buf_cnt         <= '0;
      out_valid       <= 1'b0;
    end else begin
      byte_phase      <= byte_phase_next;
      payload_left    <= payload_left_next;
      count_high_hold <= count_high_hold_next;
      literal_left    <= literal_left_next;
      repeat_count    <= repeat_count_next;
      delta_phase     <= delta_phase_next;
      base_high_hold  <= base_high_hold_next;
      cur_elev        <= cur_elev_next;
      row_elev_count  <= row_elev_count_next;
      row_index       <= row_index_next;
      min_seen        <= min_seen_next;
      max_seen        <= max_seen_next;
      feed_left       <= feed_left_next;
      row_done        <= row_done_next;
      buf_cnt         <= buf_cnt_next;
      out_valid       <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      byte_q <= data_byte;
    end
    if (cmd.feed && elev_now) begin
      if (buf_full) begin
        lanes[0] <= fd_elev;
      end else begin
        lanes[buf_cnt[LANE_IDX_W-1:0]] <= fd_elev;
      end
    end
    if (push) begin
      for (int i = 0; i < OUT_LANES; i++) begin
        out_lane[i] <= (LANE_CNT_W'(i) < buf_cnt) ? $signed(lanes[i]) : '0;
      end
      lane_count  <= buf_cnt;
      row_end     <= cmd.flush && row_done;
      grid_end    <= cmd.flush && row_done && close_grid;
      short_row   <= cmd.flush && row_done && close_short;
      running_min <= min_seen;
      running_max <= max_seen;
    end
  end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the run-length and delta elevation decoder. A
// scoreboard class predicts the elevation groups of every byte transfer and
// checks each result transfer against the oldest prediction. A short
// directed opening is followed by randomly built rows over a series of grid
// sizes, with random gaps and stalls on both streams.
// ---------------------------------------------------------------------------
module tb;
  import pbde_pkg::*;

  localparam int MAX_GRID      = 4096;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 300;
  localparam int PHASE_BYTES   = 8;
  localparam int unsigned GRID_PLAN [10] = '{2, 0, 5, 1, 4096, 3, 8191, 258, 7, 4};
  localparam logic [BYTE_W-1:0] OPENING [21] = '{
    8'h00, 8'h00,
    8'h00, 8'h0A, 8'h01, 8'h80, 8'h00, 8'h80, 8'h7F, 8'h00, 8'h80, 8'h01, 8'h7F, 8'hFF,
    8'h00, 8'h02, 8'h05, 8'h11,
    8'h00, 8'h01, 8'hFF
  };

  typedef struct packed {
    logic [OUT_LANES-1:0][ELEV_W-1:0] lanes;
    logic [LANE_CNT_W-1:0]            lane_cnt;
    logic                             row_end;
    logic                             grid_end;
    logic                             short_row;
    logic [ELEV_W-1:0]                min_elev;
    logic [ELEV_W-1:0]                max_elev;
  } elev_group_t;

  class elev_scoreboard;
    elev_group_t               expected[$];
    int                        errors;
    int                        groups_seen;
    logic [GRID_W-1:0]         grid_cfg;
    byte_phase_t               stream_phase;
    delta_phase_t              delta_state;
    logic [15:0]               bytes_left;
    logic [BYTE_W-1:0]         count_msb;
    logic [BYTE_W-1:0]         literal_run;
    logic [BYTE_W-1:0]         repeat_run;
    logic [BYTE_W-1:0]         base_msb;
    logic [ELEV_W-1:0]         cur_elev;
    logic [GRID_W-1:0]         elevs_in_row;
    logic [GRID_W-1:0]         rows_done;
    logic signed [ELEV_W-1:0]  grid_min;
    logic signed [ELEV_W-1:0]  grid_max;
    logic [ELEV_W-1:0]         fresh[$];

    function new();
      errors       = 0;
      groups_seen  = 0;
      grid_cfg     = GRID_RESET;
      stream_phase = PH_CNT_HI;
      delta_state  = DP_HIGH;
      bytes_left   = '0;
      count_msb    = '0;
      literal_run  = '0;
      repeat_run   = '0;
      base_msb     = '0;
      cur_elev     = '0;
      elevs_in_row = '0;
      rows_done    = '0;
      grid_min     = ELEV_MAX;
      grid_max     = ELEV_MIN;
    endfunction

    function void set_grid(logic [GRID_W-1:0] v);
      grid_cfg = v;
    endfunction

    function int unsigned grid_eff();
      if (grid_cfg < 2) return 2;
      if (grid_cfg > MAX_GRID) return MAX_GRID;
      return grid_cfg;
    endfunction

    function void delta_step(logic [BYTE_W-1:0] b);
      if (elevs_in_row >= grid_eff()) return;
      if (delta_state == DP_HIGH) begin
        base_msb    = b;
        delta_state = DP_LOW;
        return;
      end
      if (delta_state == DP_LOW) begin
        cur_elev    = {base_msb, b};
        delta_state = DP_RUN;
      end else if (b == ESCAPE_BYTE) begin
        delta_state = DP_HIGH;
        return;
      end else begin
        cur_elev = cur_elev + {{8{b[7]}}, b};
      end
      elevs_in_row = elevs_in_row + GRID_W'(1);
      fresh.push_back(cur_elev);
    endfunction

    function void note_byte(logic [BYTE_W-1:0] b);
      bit          row_done;
      bit          is_short;
      bit          at_grid_end;
      bit          last;
      int          idx;
      int          lanes;
      logic [ELEV_W-1:0] e;
      elev_group_t grp;
      row_done    = 1'b0;
      is_short    = 1'b0;
      at_grid_end = 1'b0;
      fresh.delete();
      case (stream_phase)
        PH_CNT_HI: begin
          count_msb    = b;
          stream_phase = PH_CNT_LO;
        end
        PH_CNT_LO: begin
          bytes_left   = {count_msb, b};
          elevs_in_row = '0;
          delta_state  = DP_HIGH;
          literal_run  = '0;
          repeat_run   = '0;
          if (bytes_left == 0) row_done = 1'b1;
          else stream_phase = PH_CODE;
        end
        PH_CODE: begin
          bytes_left = bytes_left - 16'd1;
          if (b == 0 || b[7]) begin
            repeat_run   = 8'd0 - b;
            stream_phase = PH_REP_VAL;
          end else begin
            literal_run  = b + 8'd1;
            stream_phase = PH_LITERAL;
          end
          if (bytes_left == 0) row_done = 1'b1;
        end
        PH_REP_VAL: begin
          bytes_left = bytes_left - 16'd1;
          for (int k = 0; k <= repeat_run; k++) delta_step(b);
          stream_phase = PH_CODE;
          if (bytes_left == 0) row_done = 1'b1;
        end
        PH_LITERAL: begin
          bytes_left = bytes_left - 16'd1;
          delta_step(b);
          if (literal_run > 0) literal_run = literal_run - 8'd1;
          if (literal_run == 0) stream_phase = PH_CODE;
          if (bytes_left == 0) row_done = 1'b1;
        end
        default: stream_phase = PH_CNT_HI;
      endcase

      if (row_done) begin
        stream_phase = PH_CNT_HI;
        literal_run  = '0;
        repeat_run   = '0;
        is_short     = elevs_in_row < grid_eff();
        rows_done    = rows_done + GRID_W'(1);
        at_grid_end  = rows_done >= grid_eff();
      end

      if (fresh.size() == 0 && !row_done) return;

      idx = 0;
      do begin
        lanes = fresh.size() - idx;
        if (lanes > OUT_LANES) lanes = OUT_LANES;
        grp = '0;
        for (int k = 0; k < lanes; k++) begin
          e = fresh[idx + k];
          if ($signed(e) < grid_min) grid_min = e;
          if ($signed(e) > grid_max) grid_max = e;
          grp.lanes[k] = e;
        end
        idx += lanes;
        last           = idx >= fresh.size();
        grp.lane_cnt   = LANE_CNT_W'(lanes);
        grp.row_end    = last && row_done;
        grp.grid_end   = last && row_done && at_grid_end;
        grp.short_row  = last && row_done && is_short;
        grp.min_elev   = grid_min;
        grp.max_elev   = grid_max;
        expected.push_back(grp);
      end while (idx < fresh.size());

      if (row_done && at_grid_end) begin
        rows_done = '0;
        grid_min  = ELEV_MAX;
        grid_max  = ELEV_MIN;
      end
    endfunction

    task report(string field, logic [ELEV_W-1:0] got, logic [ELEV_W-1:0] want);
      errors++;
      $display("MISMATCH group %0d %s: got %h, want %h", groups_seen, field, got, want);
    endtask

    task check_group(elev_group_t got);
      elev_group_t want;
      groups_seen++;
      if (expected.size() == 0) begin
        report("unexpected transfer, lane_count", ELEV_W'(got.lane_cnt), '0);
        return;
      end
      want = expected.pop_front();
      for (int k = 0; k < OUT_LANES; k++)
        if (got.lanes[k] !== want.lanes[k])
          report($sformatf("elev_lane%0d", k), got.lanes[k], want.lanes[k]);
      if (got.lane_cnt !== want.lane_cnt)
        report("lane_count", ELEV_W'(got.lane_cnt), ELEV_W'(want.lane_cnt));
      if (got.row_end !== want.row_end)
        report("row_end", ELEV_W'(got.row_end), ELEV_W'(want.row_end));
      if (got.grid_end !== want.grid_end)
        report("grid_end", ELEV_W'(got.grid_end), ELEV_W'(want.grid_end));
      if (got.short_row !== want.short_row)
        report("short_row", ELEV_W'(got.short_row), ELEV_W'(want.short_row));
      if (got.min_elev !== want.min_elev) report("running_min", got.min_elev, want.min_elev);
      if (got.max_elev !== want.max_elev) report("running_max", got.max_elev, want.max_elev);
    endtask
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [BYTE_W-1:0]        data_byte = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [ELEV_W-1:0] elev_lane0;
  logic signed [ELEV_W-1:0] elev_lane1;
  logic signed [ELEV_W-1:0] elev_lane2;
  logic signed [ELEV_W-1:0] elev_lane3;
  logic [LANE_CNT_W-1:0]    lane_count;
  logic                     row_end;
  logic                     grid_end;
  logic                     short_row;
  logic signed [ELEV_W-1:0] running_min;
  logic signed [ELEV_W-1:0] running_max;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [GRID_W-1:0]        grid_size = '0;

  elev_scoreboard    sb = new();
  bit                calm = 1'b0;
  bit                hold_req = 1'b0;
  int                bytes_sent = 0;
  logic [BYTE_W-1:0] row_bytes[$];

  packbits_delta_elevation_decoder_core #(.MAX_GRID(MAX_GRID)) u_top (.*);

  always #4 clk = ~clk;

  function automatic int idle_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int run_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 6);
    if (r < 90) return $urandom_range(7, 40);
    return $urandom_range(100, 129);
  endfunction

  function automatic logic [BYTE_W-1:0] content_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return ESCAPE_BYTE;
    if (r < 50) return BYTE_W'(int'($urandom_range(0, 8)) - 4);
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  // Packets of random content; a few rows come out empty or cut short.
  function automatic void make_row();
    logic [BYTE_W-1:0] body[$];
    logic [15:0]       len16;
    int                run;
    int                kind;
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(0, 2) == 0) begin
        run = run_length();
        body.push_back(BYTE_W'(1 - run));
        body.push_back(content_byte());
      end else begin
        run = ($urandom_range(0, 24) == 0) ? $urandom_range(9, 128) : $urandom_range(2, 8);
        body.push_back(BYTE_W'(run - 1));
        repeat (run) body.push_back(content_byte());
      end
    end
    kind = $urandom_range(0, 99);
    if (kind < 6) body.delete();
    else if (kind < 20)
      repeat ($urandom_range(1, 2)) if (body.size() > 1) void'(body.pop_back());
    len16 = 16'(body.size());
    row_bytes.delete();
    row_bytes.push_back(len16[15:8]);
    row_bytes.push_back(len16[7:0]);
    foreach (body[i]) row_bytes.push_back(body[i]);
  endfunction

  task automatic send_byte(logic [BYTE_W-1:0] b);
    int gap;
    in_valid  <= 1'b1;
    data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_byte(b);
    bytes_sent++;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_grid(logic [GRID_W-1:0] v);
    cfg_valid <= 1'b1;
    grid_size <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_grid(v);
  endtask

  task automatic settle();
    while (sb.expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int budget;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    foreach (OPENING[i]) send_byte(OPENING[i]);
    in_valid <= 1'b0;
    settle();
    foreach (GRID_PLAN[p]) begin
      calm = (p == 1) || ($urandom_range(0, 3) == 0);
      write_grid(GRID_W'(GRID_PLAN[p]));
      if (p == 4) hold_req = 1'b1;
      budget = bytes_sent + PHASE_BYTES;
      while (bytes_sent < budget) begin
        make_row();
        foreach (row_bytes[i]) send_byte(row_bytes[i]);
      end
      in_valid <= 1'b0;
      settle();
    end
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : result_sink
    int          stall_left;
    int          r;
    elev_group_t got;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        got.lanes[0]  = elev_lane0;
        got.lanes[1]  = elev_lane1;
        got.lanes[2]  = elev_lane2;
        got.lanes[3]  = elev_lane3;
        got.lane_cnt  = lane_count;
        got.row_end   = row_end;
        got.grid_end  = grid_end;
        got.short_row = short_row;
        got.min_elev  = running_min;
        got.max_elev  = running_max;
        sb.check_group(got);
      end
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      r = $urandom_range(0, 99);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (calm || r < 65) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b1;
        stall_left = (r < 93) ? $urandom_range(0, 2) : $urandom_range(9, 39);
      end
    end
  end

  initial begin : watchdog
    #15_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
